// ----- hdl/bblc_pkg.sv -----
// bblc_pkg: shared types, codes and sizes for the byte budget lru cache
// used by bblc_ctrl, bblc_dp and byte_budget_lru_cache_top; no dependencies
`default_nettype none

package bblc_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_BITS = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OVH_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int IN_TDATA_W = 104;
	localparam int OUT_TDATA_W = 104;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DROP = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_OVER = 2'd2;

	localparam logic KIND_EVICT = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = 1'd1;

	localparam logic [DATA_W-1:0] BUDGET_RESET = 32'd4194304;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_MATCH,
		ACT_EVICT,
		ACT_OVER,
		ACT_STORE,
		ACT_GET,
		ACT_DROP,
		ACT_ECHO
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_GET_OUT,
		ST_BUDGET,
		ST_FULL,
		ST_STORE
	} state_t;

	typedef struct packed {
		logic load;
		act_t act;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic sum_gt;
		logic empty;
		logic full;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- hdl/bblc_ctrl.sv -----
// bblc_ctrl: sequencer for get, put with evictions, drop and unused codes
// depends on bblc_pkg; drives bblc_dp through cmd_t and reads stat_t
`default_nettype none

module bblc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire bblc_pkg::stat_t stat,
	output bblc_pkg::cmd_t cmd
);

	bblc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bblc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.act = bblc_pkg::ACT_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			bblc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = bblc_pkg::ST_DECODE;
				end
			end
			bblc_pkg::ST_DECODE: begin
				if (stat.opcode == bblc_pkg::OP_GET) begin
					cmd.act = bblc_pkg::ACT_MATCH;
					state_d = bblc_pkg::ST_GET_OUT;
				end else if (stat.opcode == bblc_pkg::OP_PUT) begin
					state_d = bblc_pkg::ST_BUDGET;
				end else if (stat.out_free) begin
					cmd.act = (stat.opcode == bblc_pkg::OP_DROP) ?
						bblc_pkg::ACT_DROP : bblc_pkg::ACT_ECHO;
					state_d = bblc_pkg::ST_IDLE;
				end
			end
			bblc_pkg::ST_GET_OUT: begin
				if (stat.out_free) begin
					cmd.act = bblc_pkg::ACT_GET;
					state_d = bblc_pkg::ST_IDLE;
				end
			end
			bblc_pkg::ST_BUDGET: begin
				priority if (!stat.sum_gt) begin
					state_d = bblc_pkg::ST_FULL;
				end else if (stat.empty) begin
					cmd.act = bblc_pkg::ACT_OVER;
					state_d = bblc_pkg::ST_FULL;
				end else if (stat.out_free) begin
					cmd.act = bblc_pkg::ACT_EVICT;
				end
			end
			bblc_pkg::ST_FULL: begin
				if (!stat.full) begin
					state_d = bblc_pkg::ST_STORE;
				end else if (stat.out_free) begin
					cmd.act = bblc_pkg::ACT_EVICT;
					state_d = bblc_pkg::ST_STORE;
				end
			end
			bblc_pkg::ST_STORE: begin
				if (stat.out_free) begin
					cmd.act = bblc_pkg::ACT_STORE;
					state_d = bblc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bblc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/bblc_dp.sv -----
// bblc_dp: entry table, recency ranks, byte accounting and output register
// depends on bblc_pkg; commanded by bblc_ctrl
`default_nettype none

module bblc_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [bblc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bblc_pkg::DATA_W-1:0] cfg_wdata,
	input wire logic [bblc_pkg::IN_TDATA_W-1:0] s_tdata,
	input wire logic [1:0] s_tuser,
	input wire bblc_pkg::cmd_t cmd,
	output bblc_pkg::stat_t stat,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [bblc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tuser,
	output logic m_tlast
);

	localparam int D = bblc_pkg::DEPTH;
	localparam int IW = bblc_pkg::IDX_W;
	localparam int CW = bblc_pkg::CNT_W;
	localparam int KW = bblc_pkg::KEY_BITS;
	localparam int DW = bblc_pkg::DATA_W;

	// item registers
	logic [1:0] op_q;
	logic [KW-1:0] key_q;
	logic prom_q;
	logic [DW-1:0] hdl_q;
	logic [DW-1:0] bytes_q;
	logic over_q;

	// entry table
	logic [KW-1:0] ekey_q [D];
	logic [DW-1:0] eref_q [D];
	logic [DW-1:0] esize_q [D];
	logic [D-1:0] valid_q;
	logic [IW-1:0] rank_q [D];
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] used_q;
	logic [DW-1:0] budget_q;
	logic [bblc_pkg::OVH_W-1:0] ovh_q;

	logic [IW-1:0] hit_idx_q;
	logic found_q;

	// output register
	logic mv_q, kind_q, found_o_q, last_q;
	logic [DW-1:0] hdl_o_q, key_o_q, used_o_q;
	logic [1:0] stat_o_q;

	logic [D-1:0] match, win, oldest;
	logic [IW-1:0] win_idx, old_idx, free_idx, rd_idx, old_rank, hit_rank;
	logic win_any;
	logic [DW:0] sum;
	logic [DW-1:0] rd_ref, rd_size, used_sub, used_add;
	logic [KW-1:0] rd_key;
	logic [CW-1:0] cnt_m1;
	logic out_free;
	logic emit_beat;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			match[i] = valid_q[i] && (ekey_q[i] == key_q);
		end
		for (int i = 0; i < D; i++) begin
			win[i] = match[i];
			for (int j = 0; j < D; j++) begin
				if (j != i && match[j] && rank_q[j] < rank_q[i]) begin
					win[i] = 1'b0;
				end
			end
		end
		cnt_m1 = cnt_q - CW'(1);
		old_rank = cnt_m1[IW-1:0];
		for (int i = 0; i < D; i++) begin
			oldest[i] = valid_q[i] && (rank_q[i] == old_rank);
		end
		win_idx = '0;
		old_idx = '0;
		for (int i = 0; i < D; i++) begin
			if (win[i]) begin
				win_idx = win_idx | IW'(i);
			end
			if (oldest[i]) begin
				old_idx = old_idx | IW'(i);
			end
		end
		win_any = |match;
		free_idx = '0;
		for (int i = D - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign rd_idx = (cmd.act == bblc_pkg::ACT_GET) ? hit_idx_q : old_idx;
	assign rd_ref = eref_q[rd_idx];
	assign rd_key = ekey_q[rd_idx];
	assign rd_size = esize_q[rd_idx];
	assign hit_rank = rank_q[hit_idx_q];

	assign sum = {1'b0, used_q} + {1'b0, bytes_q};
	assign used_sub = (used_q >= rd_size) ? (used_q - rd_size) : '0;
	assign used_add = sum[DW] ? '1 : sum[DW-1:0];

	assign out_free = !mv_q || m_tready;

	// commands that load a result beat
	assign emit_beat = (cmd.act == bblc_pkg::ACT_EVICT) || (cmd.act == bblc_pkg::ACT_STORE) ||
		(cmd.act == bblc_pkg::ACT_GET) || (cmd.act == bblc_pkg::ACT_DROP) ||
		(cmd.act == bblc_pkg::ACT_ECHO);

	assign stat.opcode = op_q;
	assign stat.sum_gt = sum > {1'b0, budget_q};
	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == CW'(D));
	assign stat.out_free = out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= bblc_pkg::BUDGET_RESET;
			ovh_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bblc_pkg::REG_BUDGET) begin
				budget_q <= cfg_wdata;
			end
			if (cfg_index == bblc_pkg::REG_OVERHEAD) begin
				ovh_q <= cfg_wdata[bblc_pkg::OVH_W-1:0];
			end
		end
	end

	// item capture and payload of the table
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= s_tuser;
			key_q <= KW'(s_tdata[31:0]);
			prom_q <= s_tdata[32];
			hdl_q <= s_tdata[64:33];
			bytes_q <= s_tdata[96:65];
		end
		if (cmd.act == bblc_pkg::ACT_MATCH) begin
			hit_idx_q <= win_idx;
		end
		if (cmd.act == bblc_pkg::ACT_STORE) begin
			ekey_q[free_idx] <= key_q;
			eref_q[free_idx] <= hdl_q;
			esize_q[free_idx] <= bytes_q;
		end
	end

	// control state of the table and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < D; i++) begin
				rank_q[i] <= '0;
			end
			cnt_q <= '0;
			used_q <= '0;
			found_q <= 1'b0;
			over_q <= 1'b0;
			mv_q <= 1'b0;
			kind_q <= 1'b0;
			found_o_q <= 1'b0;
			last_q <= 1'b0;
			hdl_o_q <= '0;
			key_o_q <= '0;
			used_o_q <= '0;
			stat_o_q <= '0;
		end else begin
			if (emit_beat) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			if (cmd.load) begin
				over_q <= 1'b0;
			end
			unique case (cmd.act)
				bblc_pkg::ACT_NONE: begin
				end
				bblc_pkg::ACT_MATCH: begin
					found_q <= win_any;
				end
				bblc_pkg::ACT_OVER: begin
					over_q <= 1'b1;
				end
				bblc_pkg::ACT_EVICT: begin
					valid_q[old_idx] <= 1'b0;
					cnt_q <= cnt_m1;
					used_q <= used_sub;
					kind_q <= bblc_pkg::KIND_EVICT;
					found_o_q <= 1'b0;
					hdl_o_q <= rd_ref;
					key_o_q <= DW'(rd_key);
					stat_o_q <= bblc_pkg::STAT_OK;
					used_o_q <= used_sub;
					last_q <= 1'b0;
				end
				bblc_pkg::ACT_STORE: begin
					for (int i = 0; i < D; i++) begin
						if (valid_q[i] && IW'(i) != free_idx) begin
							rank_q[i] <= rank_q[i] + IW'(1);
						end
					end
					rank_q[free_idx] <= '0;
					valid_q[free_idx] <= 1'b1;
					cnt_q <= cnt_q + CW'(1);
					used_q <= used_add;
					kind_q <= bblc_pkg::KIND_FINAL;
					found_o_q <= 1'b0;
					hdl_o_q <= '0;
					key_o_q <= DW'(key_q);
					stat_o_q <= over_q ? bblc_pkg::STAT_OVER : bblc_pkg::STAT_OK;
					used_o_q <= used_add;
					last_q <= 1'b1;
				end
				bblc_pkg::ACT_GET: begin
					if (found_q && prom_q) begin
						for (int i = 0; i < D; i++) begin
							if (valid_q[i] && rank_q[i] < hit_rank) begin
								rank_q[i] <= rank_q[i] + IW'(1);
							end
						end
						rank_q[hit_idx_q] <= '0;
					end
					kind_q <= bblc_pkg::KIND_FINAL;
					found_o_q <= found_q;
					hdl_o_q <= found_q ? rd_ref : '0;
					key_o_q <= DW'(key_q);
					stat_o_q <= found_q ? bblc_pkg::STAT_OK : bblc_pkg::STAT_MISS;
					used_o_q <= used_q;
					last_q <= 1'b1;
				end
				bblc_pkg::ACT_DROP: begin
					valid_q <= '0;
					cnt_q <= '0;
					used_q <= DW'(ovh_q);
					kind_q <= bblc_pkg::KIND_FINAL;
					found_o_q <= 1'b0;
					hdl_o_q <= '0;
					key_o_q <= '0;
					stat_o_q <= bblc_pkg::STAT_OK;
					used_o_q <= DW'(ovh_q);
					last_q <= 1'b1;
				end
				bblc_pkg::ACT_ECHO: begin
					kind_q <= bblc_pkg::KIND_FINAL;
					found_o_q <= 1'b0;
					hdl_o_q <= '0;
					key_o_q <= DW'(key_q);
					stat_o_q <= bblc_pkg::STAT_OK;
					used_o_q <= used_q;
					last_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser = kind_q;
	assign m_tlast = last_q;
	assign m_tdata = {5'd0, used_o_q, stat_o_q, key_o_q, hdl_o_q, found_o_q};

`ifndef SYNTHESIS
	a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("entry count out of step with valid bits");

	a_evict_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == bblc_pkg::ACT_EVICT |-> cnt_q != '0 && $onehot(oldest))
		else $error("eviction without a unique oldest entry");

	a_store_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == bblc_pkg::ACT_STORE |-> cnt_q < CW'(D))
		else $error("store into a full table");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.act == bblc_pkg::ACT_EVICT || cmd.act == bblc_pkg::ACT_STORE ||
		 cmd.act == bblc_pkg::ACT_GET) |-> out_free)
		else $error("result written over a waiting beat");
`endif

endmodule

`default_nettype wire

// ----- hdl/byte_budget_lru_cache_top.sv -----
// byte_budget_lru_cache_top: size weighted lru cache, top level
// depends on bblc_pkg, bblc_ctrl and bblc_dp
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata, s_tuser (opcode)
// m_*      | out | m_tvalid/m_tready  | m_tdata, m_tuser (result_kind), m_tlast
// cfg_*    | in  | cfg_we             | cfg_index, cfg_wdata
//
// get: idle, decode, get_out; drop and unused codes: idle, decode
// put: idle, decode, budget check (repeated per budget eviction), table full check
// and store, the state machine stepping them one beat at a time
// one item in flight; the next beat is taken while the last result still waits
// a stalled output holds the sequencer; reset empties the table at once
`default_nettype none

module byte_budget_lru_cache_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [bblc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [bblc_pkg::DATA_W-1:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// key, promote, entry_handle, entry_bytes, zero pad
	input wire logic [bblc_pkg::IN_TDATA_W-1:0] s_tdata,
	// opcode
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// found, handle_out, key_out, status, used_out, zero pad
	output logic [bblc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// result_kind
	output logic m_tuser,
	output logic m_tlast
);

	bblc_pkg::cmd_t cmd;
	bblc_pkg::stat_t stat;

	bblc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	bblc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd(cmd),
		.stat(stat),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule

`default_nettype wire

// ----- verif/tb_byte_budget_lru_cache_top.sv -----
// tb_byte_budget_lru_cache_top: self-checking testbench for the byte budget lru cache
// depends on bblc_pkg and byte_budget_lru_cache_top; a scoreboard class predicts
// every result beat from its own copy of the table, budget and used byte count
`default_nettype none

module tb_byte_budget_lru_cache_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bblc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic kind;
		logic found;
		logic [31:0] handle;
		logic [31:0] key;
		logic [1:0] status;
		logic [31:0] used;
		logic last;
	} cache_result_t;

	class lru_budget_scoreboard;
		logic [31:0] budget;
		logic [31:0] overhead;
		logic [31:0] slot_key[DEPTH];
		logic [31:0] slot_ref[DEPTH];
		logic [31:0] slot_size[DEPTH];
		bit slot_valid[DEPTH];
		int slot_rank[DEPTH];
		logic [31:0] used;
		cache_result_t expected_results[$];
		int errors;

		function new();
			budget = BUDGET_RESET;
			overhead = 0;
			used = 0;
			errors = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 0;
				slot_rank[i] = 0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == REG_BUDGET)
				budget = value;
			else
				overhead = {16'd0, value[15:0]};
		endfunction

		function void push(logic kind, logic found, logic [31:0] handle, logic [31:0] key,
				logic [1:0] status, logic last);
			cache_result_t r;
			r = '{kind, found, handle, key, status, used, last};
			expected_results.push_back(r);
		endfunction

		function int evict_lru();
			int best;
			best = -1;
			for (int i = 0; i < DEPTH; i++)
				if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best]))
					best = i;
			if (best >= 0) begin
				slot_valid[best] = 0;
				used = (used >= slot_size[best]) ? used - slot_size[best] : 32'd0;
				push(KIND_EVICT, 0, slot_ref[best], slot_key[best], STAT_OK, 0);
			end
			return best;
		endfunction

		function void move_to_front(int s, int limit);
			for (int i = 0; i < DEPTH; i++)
				if (i != s && slot_valid[i] && slot_rank[i] < limit)
					slot_rank[i]++;
			slot_rank[s] = 0;
		endfunction

		function void note_item(logic [1:0] op, logic [31:0] key, logic prom,
				logic [31:0] handle, logic [31:0] bytes);
			int hit;
			int cnt;
			int slot;
			logic [1:0] status;
			logic [32:0] sum;
			case (op)
				OP_GET: begin
					hit = -1;
					for (int i = 0; i < DEPTH; i++)
						if (slot_valid[i] && slot_key[i] == key &&
								(hit < 0 || slot_rank[i] < slot_rank[hit]))
							hit = i;
					if (hit < 0)
						push(KIND_FINAL, 0, 0, key, STAT_MISS, 1);
					else begin
						if (prom)
							move_to_front(hit, slot_rank[hit]);
						push(KIND_FINAL, 1, slot_ref[hit], key, STAT_OK, 1);
					end
				end
				OP_PUT: begin
					status = STAT_OK;
					if ({1'b0, used} + {1'b0, bytes} >= {1'b0, budget})
						while ({1'b0, used} + {1'b0, bytes} > {1'b0, budget})
							if (evict_lru() < 0) begin
								status = STAT_OVER;
								break;
							end
					cnt = 0;
					foreach (slot_valid[i])
						cnt += slot_valid[i];
					if (cnt >= DEPTH)
						void'(evict_lru());
					slot = 0;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!slot_valid[i])
							slot = i;
					slot_key[slot] = key;
					slot_ref[slot] = handle;
					slot_size[slot] = bytes;
					slot_valid[slot] = 1;
					move_to_front(slot, DEPTH);
					sum = {1'b0, used} + {1'b0, bytes};
					used = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					push(KIND_FINAL, 0, 0, key, status, 1);
				end
				OP_DROP: begin
					foreach (slot_valid[i])
						slot_valid[i] = 0;
					used = overhead;
					push(KIND_FINAL, 0, 0, 0, STAT_OK, 1);
				end
				default: push(KIND_FINAL, 0, 0, key, STAT_OK, 1);
			endcase
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("beat mismatch on %s: got %h want %h", field, got, want);
			errors++;
		endtask

		task check_result(cache_result_t got);
			cache_result_t want;
			if (expected_results.size() == 0) begin
				report("unexpected beat", got.key, 0);
				return;
			end
			want = expected_results.pop_front();
			if (got.kind !== want.kind) report("result_kind", got.kind, want.kind);
			if (got.found !== want.found) report("found", got.found, want.found);
			if (got.handle !== want.handle) report("handle_out", got.handle, want.handle);
			if (got.key !== want.key) report("key_out", got.key, want.key);
			if (got.status !== want.status) report("status", got.status, want.status);
			if (got.used !== want.used) report("used_out", got.used, want.used);
			if (got.last !== want.last) report("last", got.last, want.last);
		endtask
	endclass

	logic clk;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	lru_budget_scoreboard sb = new();
	int quiet_cycles = 0;
	int beats_taken = 0;
	bit long_hold_done = 0;
	bit send_burst = 0;
	logic [31:0] budget_now = BUDGET_RESET;

	byte_budget_lru_cache_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1;
		#5;
		clk = 0;
		#5;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls, one long hold once traffic is flowing
	initial begin
		int stall;
		cache_result_t got;
		wait (arst_n);
		forever begin
			stall = send_burst ? 0 : $urandom_range(0, 6);
			if (!long_hold_done && beats_taken > 120) begin
				stall = 400;
				long_hold_done = 1;
			end
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got.kind = m_tuser;
			got.found = m_tdata[0];
			got.handle = m_tdata[32:1];
			got.key = m_tdata[64:33];
			got.status = m_tdata[66:65];
			got.used = m_tdata[98:67];
			got.last = m_tlast;
			sb.check_result(got);
			beats_taken++;
			@(negedge clk);
		end
	end

	task send_item(logic [1:0] op, logic [31:0] key, logic prom, logic [31:0] handle,
			logic [31:0] bytes);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {7'd0, bytes, handle, prom, key};
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, key, prom, handle, bytes);
		@(negedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, value);
		if (idx == REG_BUDGET)
			budget_now = value;
	endtask

	task settle();
		s_tvalid <= 0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task random_item();
		logic [1:0] op;
		logic [31:0] key;
		logic [31:0] bytes;
		int pick;
		pick = $urandom_range(0, 99);
		op = pick < 45 ? OP_PUT : pick < 88 ? OP_GET : pick < 95 ? OP_DROP : OP_UNUSED;
		key = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 11)) : $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			bytes = $urandom_range(0, budget_now / 4 + 1);
		else if (pick < 8)
			bytes = $urandom_range(0, 64);
		else
			bytes = $urandom;
		send_item(op, key, $urandom_range(0, 1), $urandom, bytes);
	endtask

	initial begin
		logic [31:0] budgets[6];
		logic [31:0] overheads[6];
		budgets = '{BUDGET_RESET, 1000, 0, 32'hFFFF_FFFF, 5000, $urandom};
		overheads = '{0, 100, 65535, 0, 1234, $urandom_range(0, 65535)};
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		write_reg(REG_BUDGET, BUDGET_RESET);
		write_reg(REG_OVERHEAD, 0);

		send_item(OP_GET, 32'h0, 1, 32'h0, 32'h0);
		send_item(OP_PUT, 32'h0, 0, 32'hFFFF_FFFF, 32'h0);
		send_item(OP_PUT, 32'hFFFF_FFFF, 1, 32'h0, 32'd4194304);
		send_item(OP_PUT, 32'h0, 0, 32'h1234_5678, 32'd10);
		send_item(OP_GET, 32'h0, 0, 32'h0, 32'h0);
		send_item(OP_GET, 32'h0, 1, 32'h0, 32'h0);
		send_item(OP_UNUSED, 32'hA5A5_A5A5, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_PUT, 32'h7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_PUT, 32'h8, 0, 32'h1, 32'h1);
		send_item(OP_DROP, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_burst = 1;
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(OP_PUT, 32'(i % 9), 0, 32'(i), 32'h0);
		send_burst = 0;

		foreach (budgets[p]) begin
			settle();
			write_reg(REG_BUDGET, budgets[p]);
			write_reg(REG_OVERHEAD, overheads[p]);
			send_item(OP_DROP, 0, 0, 0, 0);
			for (int n = 0; n < 70; n++) begin
				if (n % 25 == 0)
					send_burst = ~send_burst;
				random_item();
			end
			send_burst = 0;
		end

		settle();
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
